// File: rtl/stedt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stedt_pkg
// Types and constants shared by the speech turn end detector.
// ----------------------------------------------------------------------------
package stedt_pkg;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_SPEECH  = 2'd1,
    ST_SILENCE = 2'd2
  } turn_state_t;

  localparam logic [1:0] CFG_MIN_UTT  = 2'd0;
  localparam logic [1:0] CFG_SIL_BASE = 2'd1;
  localparam logic [1:0] CFG_SIL_EXT  = 2'd2;
  localparam logic [1:0] CFG_TURN_THR = 2'd3;

  localparam logic [15:0] MIN_UTT_RST  = 16'd300;
  localparam logic [15:0] SIL_BASE_RST = 16'd1000;
  localparam logic [15:0] SIL_EXT_RST  = 16'd2000;
  localparam logic [10:0] TURN_THR_RST = 11'd512;

  // Q0.10 breakpoints: 0.2 as 5p vs 1024, 0.5 as p vs 512
  localparam logic [12:0] P_LOW_X5  = 13'd1024;
  localparam logic [9:0]  P_HIGH    = 10'd512;

  typedef struct packed {
    logic [1:0]  vad_code;
    logic        vad_failed;
    logic [9:0]  turn_prob;
    logic        turn_failed;
    logic        buffer_empty;
    logic [31:0] now_ms;
  } stedt_in_t;

  typedef struct packed {
    logic [1:0]  state_after;
    logic        talk_start;
    logic        talk_end;
    logic        backchannel;
    logic        turn_done;
    logic        by_timeout;
    logic [31:0] event_ms;
  } stedt_out_t;

endpackage

// File: rtl/speech_turn_end_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speech_turn_end_detector_top
// Tracks idle/speech/silence per voice activity chunk and flags speech start,
// speech end, backchannel and turn completion by probability or timeout.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; state updates as the item
//   enters the result register.
// Throughput: one request per cycle while the result side does not stall; set by the single decision stage.
// Reset: synchronous, active low; clears state to idle, start times to zero,
//   registers to their defaults and both valid flags.
module speech_turn_end_detector_top
  import stedt_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  stedt_in_t   in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output stedt_out_t  out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  localparam int XW = TIME_BITS + 1;

  logic [15:0] min_utt_r;
  logic [15:0] sil_base_r;
  logic [15:0] sil_ext_r;
  logic [10:0] turn_thr_r;

  logic        s1_valid_r;
  stedt_in_t   s1_data_r;
  logic        out_valid_r;
  stedt_out_t  out_data_r;
  stedt_out_t  out_data_nxt;

  turn_state_t          state_r, state_nxt;
  logic [TIME_BITS-1:0] sp_start_r, sp_start_nxt;
  logic [TIME_BITS-1:0] sil_start_r, sil_start_nxt;

  logic out_free;
  logic adv;

  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_utt_r  <= MIN_UTT_RST;
      sil_base_r <= SIL_BASE_RST;
      sil_ext_r  <= SIL_EXT_RST;
      turn_thr_r <= TURN_THR_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_UTT:  min_utt_r  <= cfg_wdata;
        CFG_SIL_BASE: sil_base_r <= cfg_wdata;
        CFG_SIL_EXT:  sil_ext_r  <= cfg_wdata;
        CFG_TURN_THR: turn_thr_r <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // decode
  logic [TIME_BITS-1:0] now_w;
  logic [1:0]           v;
  logic [9:0]           p;
  logic                 cur_speech, cur_silence, cur_idle;

  assign now_w       = TIME_BITS'(s1_data_r.now_ms);
  assign v           = s1_data_r.vad_code;
  assign p           = s1_data_r.turn_prob;
  assign cur_idle    = (state_r == ST_IDLE);
  assign cur_speech  = (state_r == ST_SPEECH);
  assign cur_silence = (state_r == ST_SILENCE);

  // durations
  logic [TIME_BITS-1:0] dur;
  logic [TIME_BITS-1:0] sil;
  logic                 too_short;

  assign dur       = now_w - sp_start_r;
  assign sil       = cur_speech ? '0 : (now_w - sil_start_r);
  assign too_short = dur < TIME_BITS'(min_utt_r);

  // timeout compare, interpolation without a divider:
  // ext >= base: sil >= ext - floor(prod/1536)  <=>  prod >= (ext - sil) * 1536
  // ext <  base: sil >= ext + floor(prod/1536)  <=>  (sil - ext + 1) * 1536 > prod
  logic [12:0] five_p;
  logic        p_low, p_high;
  logic [10:0] frac;
  logic        ext_ge_base;
  logic [15:0] span;
  logic [26:0] prod;
  logic [XW-1:0] sil_x, ext_x, base_x, diff_x;
  logic        sil_ge_ext, sil_ge_base;
  logic [15:0] d_dn;
  logic [26:0] d_dn_sc;
  logic [16:0] e_up;
  logic [27:0] e_up_sc;
  logic        reached_dn, reached_up, reached;
  logic        complete;

  assign five_p      = 13'(p) + 13'({p, 2'b00});
  assign p_low       = five_p < P_LOW_X5;
  assign p_high      = p >= P_HIGH;
  assign frac        = 11'(five_p - P_LOW_X5);
  assign ext_ge_base = sil_ext_r >= sil_base_r;
  assign span        = ext_ge_base ? (sil_ext_r - sil_base_r) : (sil_base_r - sil_ext_r);
  assign prod        = 27'(frac) * 27'(span);

  assign sil_x       = XW'(sil);
  assign ext_x       = XW'(sil_ext_r);
  assign base_x      = XW'(sil_base_r);
  assign sil_ge_ext  = sil_x >= ext_x;
  assign sil_ge_base = sil_x >= base_x;
  assign diff_x      = sil_x - ext_x;

  assign d_dn        = sil_ext_r - sil[15:0];
  assign d_dn_sc     = 27'({d_dn, 10'b0}) + 27'({d_dn, 9'b0});
  assign reached_dn  = sil_ge_ext || (prod >= d_dn_sc);

  assign e_up        = 17'(diff_x[15:0]) + 17'd1;
  assign e_up_sc     = 28'({e_up, 10'b0}) + 28'({e_up, 9'b0});
  assign reached_up  = sil_ge_ext &&
                       ((diff_x >= XW'(17'h10000)) || (e_up_sc > 28'(prod)));

  always_comb begin
    if (p_low) begin
      reached = sil_ge_ext;
    end else if (p_high) begin
      reached = sil_ge_base;
    end else if (ext_ge_base) begin
      reached = reached_dn;
    end else begin
      reached = reached_up;
    end
  end

  assign complete = {1'b0, p} >= turn_thr_r;

  // transition conditions
  logic go_start, go_end, go_back, go_eval, go_abort, go_done, go_resume, hit;

  assign go_start  = !s1_data_r.vad_failed && cur_idle && (v == ST_SPEECH);
  assign go_end    = !s1_data_r.vad_failed && (cur_speech || cur_silence) &&
                     (v == ST_IDLE);
  assign go_back   = go_end && cur_speech && too_short;
  assign go_eval   = go_end && !go_back;
  assign go_abort  = s1_data_r.buffer_empty || s1_data_r.turn_failed;
  assign hit       = complete || reached;
  assign go_done   = go_eval && !go_abort && hit;
  assign go_resume = !s1_data_r.vad_failed && cur_silence && (v == ST_SPEECH);

  // next state
  always_comb begin
    state_nxt     = state_r;
    sp_start_nxt  = sp_start_r;
    sil_start_nxt = sil_start_r;
    if (go_start) begin
      state_nxt    = ST_SPEECH;
      sp_start_nxt = now_w;
    end else if (go_end) begin
      if (cur_speech) begin
        sil_start_nxt = now_w;
      end
      if (go_back || (go_eval && (go_abort || hit))) begin
        state_nxt = ST_IDLE;
      end else begin
        state_nxt = ST_SILENCE;
      end
    end else if (go_resume) begin
      state_nxt = ST_SPEECH;
    end
    if (!s1_data_r.vad_failed && (v == ST_SILENCE) && (state_nxt == ST_SPEECH)) begin
      state_nxt = ST_SILENCE;
    end
  end

  // outputs
  always_comb begin
    out_data_nxt             = '0;
    out_data_nxt.state_after = state_nxt;
    out_data_nxt.talk_start  = go_start;
    out_data_nxt.talk_end    = go_eval && cur_speech;
    out_data_nxt.backchannel = go_back;
    out_data_nxt.turn_done   = go_done;
    out_data_nxt.by_timeout  = go_done && reached && !complete;
    if (go_start || (go_end && cur_speech) || go_done) begin
      out_data_nxt.event_ms = 32'(now_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sp_start_r  <= '0;
      sil_start_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        state_r     <= state_nxt;
        sp_start_r  <= sp_start_nxt;
        sil_start_r <= sil_start_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.turn_done |-> out_data_r.state_after == ST_IDLE)
    else $error("turn_done with state not idle");

  a_timeout_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.by_timeout |-> out_data_r.turn_done)
    else $error("by_timeout without turn_done");

  a_back_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.backchannel |->
      !out_data_r.talk_end && !out_data_r.turn_done &&
      out_data_r.state_after == ST_IDLE)
    else $error("backchannel mixed with other events");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(state_r))
    else $error("state changed without an item");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the speech turn end detector. A scoreboard class
// tracks the idle/speech/silence state, speech and silence start times and
// the four configuration registers. It predicts one result per accepted request and
// checks every result in order. Stimulus is a directed opening, then random
// utterance-shaped chunk streams under several register settings, extremes
// included, with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import stedt_pkg::*;

  localparam logic [1:0] VAD_UNUSED = 2'd3;

  class turn_scoreboard;
    int unsigned min_utt_ms;
    int unsigned base_ms;
    int unsigned ext_ms;
    int unsigned thr_q10;
    turn_state_t state;
    logic [31:0] speech_t0;
    logic [31:0] silence_t0;
    stedt_out_t  expected_q[$];
    int          failures;

    function new();
      min_utt_ms = 32'(MIN_UTT_RST);
      base_ms    = 32'(SIL_BASE_RST);
      ext_ms     = 32'(SIL_EXT_RST);
      thr_q10    = 32'(TURN_THR_RST);
      state      = ST_IDLE;
      speech_t0  = '0;
      silence_t0 = '0;
      failures   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_MIN_UTT:  min_utt_ms = 32'(val);
        CFG_SIL_BASE: base_ms = 32'(val);
        CFG_SIL_EXT:  ext_ms = 32'(val);
        CFG_TURN_THR: thr_q10 = 32'(val[10:0]);
        default: ;
      endcase
    endfunction

    function int unsigned time_span();
      int unsigned m;
      m = min_utt_ms;
      if (base_ms > m) m = base_ms;
      if (ext_ms > m) m = ext_ms;
      return m + 16;
    endfunction

    // linear from extended (p < 0.2) to base (p >= 0.5), truncated
    function int unsigned silence_limit(logic [9:0] p);
      int unsigned x5;
      x5 = 5 * p;
      if (x5 < P_LOW_X5) return ext_ms;
      if (p >= P_HIGH) return base_ms;
      if (ext_ms >= base_ms) return ext_ms - ((x5 - P_LOW_X5) * (ext_ms - base_ms)) / 1536;
      return ext_ms + ((x5 - P_LOW_X5) * (base_ms - ext_ms)) / 1536;
    endfunction

    function void note_request(stedt_in_t r);
      stedt_out_t  e;
      turn_state_t nxt;
      logic [31:0] held;
      logic        skip;
      logic        complete;
      logic        reached;
      e = '0;
      nxt = state;
      skip = 1'b0;
      if (!r.vad_failed) begin
        if (nxt == ST_IDLE && r.vad_code == ST_SPEECH) begin
          speech_t0 = r.now_ms;
          nxt = ST_SPEECH;
          e.talk_start = 1'b1;
        end else if (nxt != ST_IDLE && r.vad_code == ST_IDLE) begin
          if (nxt == ST_SPEECH) begin
            held = r.now_ms - speech_t0;
            silence_t0 = r.now_ms;
            if (held < min_utt_ms) begin
              nxt = ST_IDLE;
              e.backchannel = 1'b1;
              skip = 1'b1;
            end else begin
              e.talk_end = 1'b1;
            end
          end
          if (!skip) begin
            nxt = ST_SILENCE;
            if (r.buffer_empty || r.turn_failed) begin
              nxt = ST_IDLE;
            end else begin
              complete = r.turn_prob >= thr_q10;
              held = r.now_ms - silence_t0;
              reached = held >= silence_limit(r.turn_prob);
              if (complete || reached) begin
                e.turn_done = 1'b1;
                e.by_timeout = reached && !complete;
                nxt = ST_IDLE;
              end
            end
          end
        end else if (nxt == ST_SILENCE && r.vad_code == ST_SPEECH) begin
          nxt = ST_SPEECH;
        end
        if (r.vad_code == ST_SILENCE && nxt == ST_SPEECH) nxt = ST_SILENCE;
        state = nxt;
      end
      e.state_after = state;
      if (e.talk_start || e.talk_end || e.backchannel || e.turn_done)
        e.event_ms = r.now_ms;
      expected_q.push_back(e);
    endfunction

    function void report(string what, stedt_out_t e, stedt_out_t got);
      failures++;
      if (failures <= 10) begin
        $display("[%0t] %s", $time, what);
        $display("  exp st=%0d ss=%b se=%b bc=%b td=%b to=%b ms=%h", e.state_after,
                 e.talk_start, e.talk_end, e.backchannel, e.turn_done,
                 e.by_timeout, e.event_ms);
        $display("  got st=%0d ss=%b se=%b bc=%b td=%b to=%b ms=%h", got.state_after,
                 got.talk_start, got.talk_end, got.backchannel, got.turn_done,
                 got.by_timeout, got.event_ms);
      end
    endfunction

    function void check_result(stedt_out_t got);
      stedt_out_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      e = expected_q.pop_front();
      if (got.state_after !== e.state_after || got.talk_start !== e.talk_start ||
          got.talk_end !== e.talk_end || got.backchannel !== e.backchannel ||
          got.turn_done !== e.turn_done || got.by_timeout !== e.by_timeout ||
          got.event_ms !== e.event_ms)
        report("result mismatch", e, got);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  stedt_in_t   in_data;
  logic        out_valid;
  logic        out_stall;
  stedt_out_t  out_data;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  turn_scoreboard sb = new();

  bit          in_idling;
  bit          out_idling;
  bit          talking;
  int          seg_left;
  logic [31:0] t_ms;

  speech_turn_end_detector_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // result side: check, then stall in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall <= 1'b0;
      end else if (out_idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic stedt_in_t chunk(logic [1:0] v, logic vf, logic [9:0] p, logic tf,
                                      logic be, logic [31:0] t);
    stedt_in_t r;
    r.vad_code = v;
    r.vad_failed = vf;
    r.turn_prob = p;
    r.turn_failed = tf;
    r.buffer_empty = be;
    r.now_ms = t;
    return r;
  endfunction

  task automatic send_request(input stedt_in_t r);
    if (in_idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input logic [15:0] mu, input logic [15:0] base,
                           input logic [15:0] ext, input logic [10:0] thr);
    write_reg(CFG_MIN_UTT, mu);
    write_reg(CFG_SIL_BASE, base);
    write_reg(CFG_SIL_EXT, ext);
    write_reg(CFG_TURN_THR, {5'd0, thr});
    cfg_we <= 1'b0;
  endtask

  // utterance-shaped stream: speech runs then idle runs, with some noise
  task automatic next_chunk(output stedt_in_t r);
    r = '0;
    if (seg_left == 0) begin
      talking = !talking;
      seg_left = talking ? $urandom_range(1, 6) : $urandom_range(1, 10);
    end
    seg_left--;
    if (talking) r.vad_code = ($urandom_range(0, 4) == 0) ? ST_SILENCE : ST_SPEECH;
    else r.vad_code = ST_IDLE;
    if ($urandom_range(0, 9) == 0) r.vad_code = 2'($urandom_range(0, 3));
    r.vad_failed = $urandom_range(0, 19) == 0;
    r.turn_failed = $urandom_range(0, 19) == 0;
    r.buffer_empty = $urandom_range(0, 19) == 0;
    case ($urandom_range(0, 5))
      0: r.turn_prob = 10'($urandom_range(203, 206));
      1: r.turn_prob = 10'($urandom_range(510, 513));
      2: r.turn_prob = (sb.thr_q10 >= 1 && sb.thr_q10 <= 1023) ?
                       10'(sb.thr_q10 - $urandom_range(0, 1)) : 10'd1023;
      3: r.turn_prob = $urandom_range(0, 1) ? 10'd0 : 10'd1023;
      default: r.turn_prob = 10'($urandom_range(0, 1023));
    endcase
    case ($urandom_range(0, 9))
      0: t_ms = $urandom;
      1: t_ms = sb.speech_t0 + sb.min_utt_ms - $urandom_range(0, 1);
      2: t_ms = sb.silence_t0 + sb.silence_limit(r.turn_prob) - $urandom_range(0, 1);
      default: t_ms = t_ms + $urandom_range(0, sb.time_span() / 3 + 1);
    endcase
    r.now_ms = t_ms;
  endtask

  task automatic random_phase(input int n, input bit idling);
    stedt_in_t r;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        in_idling = idling && $urandom_range(0, 3) != 0;
        out_idling = idling && $urandom_range(0, 3) != 0;
      end
      next_chunk(r);
      send_request(r);
    end
  endtask

  task automatic run_directed();
    send_request(chunk(ST_IDLE, 0, 0, 0, 0, 0));
    send_request(chunk(VAD_UNUSED, 0, 0, 0, 0, 10));
    send_request(chunk(ST_SPEECH, 0, 0, 0, 0, 100));
    send_request(chunk(ST_IDLE, 1, 10'd1023, 1, 1, 150));
    send_request(chunk(ST_SILENCE, 0, 0, 0, 0, 200));
    send_request(chunk(ST_SPEECH, 0, 0, 0, 0, 250));
    send_request(chunk(VAD_UNUSED, 0, 0, 0, 0, 260));
    send_request(chunk(ST_IDLE, 0, 0, 0, 0, 399));
    send_request(chunk(ST_SPEECH, 0, 0, 0, 0, 1000));
    send_request(chunk(ST_IDLE, 0, 10'd1023, 0, 0, 1300));
    send_request(chunk(ST_SPEECH, 0, 0, 0, 0, 3000));
    send_request(chunk(ST_IDLE, 0, 0, 0, 0, 4000));
    send_request(chunk(ST_IDLE, 0, 10'd204, 0, 0, 5999));
    send_request(chunk(ST_IDLE, 0, 10'd204, 0, 0, 6000));
    send_request(chunk(ST_SPEECH, 0, 0, 0, 0, 7000));
    send_request(chunk(ST_IDLE, 0, 10'd300, 0, 0, 8000));
    send_request(chunk(ST_IDLE, 0, 10'd300, 0, 0, 9691));
    send_request(chunk(ST_SPEECH, 0, 0, 0, 0, 10000));
    send_request(chunk(ST_IDLE, 0, 10'd700, 0, 1, 11000));
    send_request(chunk(ST_SPEECH, 0, 0, 0, 0, 12000));
    send_request(chunk(ST_IDLE, 0, 10'd1023, 1, 0, 13000));
    // speech spanning the time wrap
    send_request(chunk(ST_SPEECH, 0, 0, 0, 0, 32'hFFFF_FF00));
    send_request(chunk(ST_IDLE, 0, 10'd511, 0, 0, 32'h0000_0100));
    send_request(chunk(ST_IDLE, 0, 10'd205, 0, 0, 32'hFFFF_FFFF));
    send_request(chunk(ST_SILENCE, 0, 0, 0, 0, 5));
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_MIN_UTT;
    cfg_wdata <= '0;
    in_idling = 1'b1;
    out_idling = 1'b1;
    talking = 1'b0;
    seg_left = 0;
    t_ms = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    random_phase(180, 1'b1);
    drain();
    configure(16'd0, 16'd0, 16'd0, 11'd0);
    random_phase(150, 1'b1);
    drain();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd1024);
    random_phase(150, 1'b1);
    drain();
    configure(16'd50, 16'd3000, 16'd500, 11'd700);
    random_phase(180, 1'b1);
    drain();
    configure(16'd5, 16'd0, 16'd40, 11'd1000);
    random_phase(180, 1'b1);
    repeat (3) begin
      drain();
      configure(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 4000)),
                16'($urandom_range(0, 4000)), 11'($urandom_range(0, 1024)));
      random_phase(150, 1'b1);
    end
    drain();
    configure(MIN_UTT_RST, SIL_BASE_RST, SIL_EXT_RST, TURN_THR_RST);
    random_phase(150, 1'b0);
    drain();

    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
